FILE: hdl/i2cmrt_pkg.sv
`default_nettype none

package i2cmrt_pkg;

  // Commands carried by an input item
  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_WRITE  = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;
  localparam logic [1:0] CMD_STATUS = 2'd3;

  // Transfer phases
  localparam logic [3:0] PH_IDLE    = 4'd0;
  localparam logic [3:0] PH_START   = 4'd1;
  localparam logic [3:0] PH_SLAW    = 4'd2;
  localparam logic [3:0] PH_ADDR    = 4'd3;
  localparam logic [3:0] PH_WDATA   = 4'd4;
  localparam logic [3:0] PH_RESTART = 4'd5;
  localparam logic [3:0] PH_SLAR    = 4'd6;
  localparam logic [3:0] PH_RDATA   = 4'd7;
  localparam logic [3:0] PH_LAST    = 4'd8;

  // Bus actions requested from the byte engine
  localparam logic [2:0] ACT_NONE    = 3'd0;
  localparam logic [2:0] ACT_START   = 3'd1;
  localparam logic [2:0] ACT_SEND    = 3'd2;
  localparam logic [2:0] ACT_RX_ACK  = 3'd3;
  localparam logic [2:0] ACT_RX_NACK = 3'd4;
  localparam logic [2:0] ACT_STOP    = 3'd5;
  localparam logic [2:0] ACT_RECOVER = 3'd6;

  // Engine status codes
  localparam logic [7:0] ST_BUS_ERROR  = 8'h00;
  localparam logic [7:0] ST_START      = 8'h08;
  localparam logic [7:0] ST_RESTART    = 8'h10;
  localparam logic [7:0] ST_SLAW_ACK   = 8'h18;
  localparam logic [7:0] ST_DATA_ACK   = 8'h28;
  localparam logic [7:0] ST_SLAR_ACK   = 8'h40;
  localparam logic [7:0] ST_RX_ACK     = 8'h50;
  localparam logic [7:0] ST_RX_NACK    = 8'h58;

  localparam logic [7:0] TARGET_RESET = 8'h26;

  // Status code that a phase waits for
  function automatic logic [7:0] expected_code(input logic [3:0] ph);
    logic [7:0] code;
    case (ph)
      PH_START:   code = ST_START;
      PH_SLAW:    code = ST_SLAW_ACK;
      PH_ADDR:    code = ST_DATA_ACK;
      PH_WDATA:   code = ST_DATA_ACK;
      PH_RESTART: code = ST_RESTART;
      PH_SLAR:    code = ST_SLAR_ACK;
      PH_RDATA:   code = ST_RX_ACK;
      PH_LAST:    code = ST_RX_NACK;
      default:    code = ST_BUS_ERROR;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/i2cmrt_ram.sv
`default_nettype none

module i2cmrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                       wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write one entry, read one entry into a register
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

FILE: hdl/i2c_master_register_transfer.sv
`default_nettype none

// Register read/write sequencer for an I2C master driving a byte-level bus
// engine. Load bytes (command 0) while idle, then start a write (1) or read (2);
// each status event (3) from the engine yields one result item with the next
// bus action. Every accepted item produces exactly one result item, in the cycle
// after acceptance, and a new item can be accepted every cycle unless the output
// register is stalled: the item is decoded combinationally against the phase
// register and lands in the output register. The write buffer RAM is read
// ahead at the next byte's index, so back-to-back status events see the right
// byte. The cfg port writes the target address register and is always ready.
module i2c_master_register_transfer #(
  parameter int MAX_BYTES = 16
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // configuration write
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [7:0] cfg_wdata_i,
  // input items
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [1:0] command_i,
  input  wire logic [7:0] reg_address_i,
  input  wire logic [4:0] byte_count_i,
  input  wire logic [7:0] write_data_i,
  input  wire logic [7:0] status_code_i,
  input  wire logic [7:0] rx_byte_i,
  // result items
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [2:0]      bus_action_o,
  output logic [7:0]      tx_byte_o,
  output logic [7:0]      read_data_o,
  output logic            read_valid_o,
  output logic            done_res_o,
  output logic            error_o,
  output logic [2:0]      error_stage_o
);

  localparam int AW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
  localparam int CW = $clog2(MAX_BYTES + 1);
  localparam logic [8:0] MaxCount = 9'(MAX_BYTES);
  localparam logic [CW-1:0] MaxLen = CW'(MAX_BYTES);

  logic          in_acc;
  logic [7:0]    target_q;
  logic [3:0]    phase_q, phase_d;
  logic          is_read_q, is_read_d;
  logic [7:0]    saddr_q, saddr_d;
  logic [CW-1:0] len_q, len_d;
  logic [CW-1:0] done_cnt_q, done_cnt_d;
  logic [CW-1:0] load_ptr_q, load_ptr_d;

  logic          buf_we;
  logic [AW-1:0] buf_raddr;
  logic [7:0]    buf_rdata;

  logic          out_valid_q;
  logic [2:0]    act_d, act_q;
  logic [7:0]    tx_d, tx_q;
  logic [7:0]    rdata_d, rdata_q;
  logic          rvalid_d, rvalid_q;
  logic          done_d, done_q;
  logic          err_d, err_q;
  logic [2:0]    stage_d, stage_q;

  // Handshakes: output register drains or is empty
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign in_acc      = in_valid_i & ~in_stall_o;
  assign cfg_ready_o = 1'b1;

  // Decode one item against the current phase
  always_comb begin
    logic [CW-1:0] cnt;
    logic [CW:0]   inc1;
    logic [CW:0]   inc2;
    logic [CW:0]   nxt;
    phase_d    = phase_q;
    is_read_d  = is_read_q;
    saddr_d    = saddr_q;
    len_d      = len_q;
    done_cnt_d = done_cnt_q;
    load_ptr_d = load_ptr_q;
    buf_we     = 1'b0;
    act_d      = i2cmrt_pkg::ACT_NONE;
    tx_d       = 8'h00;
    rdata_d    = 8'h00;
    rvalid_d   = 1'b0;
    done_d     = 1'b0;
    err_d      = 1'b0;
    stage_d    = 3'd0;
    cnt        = ({4'd0, byte_count_i} > MaxCount) ? MaxLen : CW'(byte_count_i);
    inc1       = {1'b0, done_cnt_q} + 1'b1;
    inc2       = inc1 + 1'b1;

    case (command_i)
      i2cmrt_pkg::CMD_LOAD: begin
        if (phase_q == i2cmrt_pkg::PH_IDLE && load_ptr_q < MaxLen) begin
          buf_we     = 1'b1;
          load_ptr_d = load_ptr_q + 1'b1;
        end
      end
      i2cmrt_pkg::CMD_WRITE, i2cmrt_pkg::CMD_READ: begin
        if (phase_q == i2cmrt_pkg::PH_IDLE) begin
          is_read_d  = (command_i == i2cmrt_pkg::CMD_READ);
          saddr_d    = reg_address_i;
          len_d      = (is_read_d && cnt == '0) ? CW'(1) : cnt;
          done_cnt_d = '0;
          if (!is_read_d) begin
            load_ptr_d = '0;
          end
          phase_d = i2cmrt_pkg::PH_START;
          act_d   = i2cmrt_pkg::ACT_START;
        end
      end
      default: begin
        if (phase_q != i2cmrt_pkg::PH_IDLE && phase_q <= i2cmrt_pkg::PH_LAST) begin
          if (status_code_i != i2cmrt_pkg::expected_code(phase_q)) begin
            // abort with the failing stage
            err_d   = 1'b1;
            done_d  = 1'b1;
            stage_d = 3'(phase_q - 4'd1);
            act_d   = (status_code_i == i2cmrt_pkg::ST_BUS_ERROR) ?
                      i2cmrt_pkg::ACT_RECOVER : i2cmrt_pkg::ACT_NONE;
            phase_d = i2cmrt_pkg::PH_IDLE;
          end else begin
            case (phase_q)
              i2cmrt_pkg::PH_START: begin
                act_d   = i2cmrt_pkg::ACT_SEND;
                tx_d    = target_q;
                phase_d = i2cmrt_pkg::PH_SLAW;
              end
              i2cmrt_pkg::PH_SLAW: begin
                act_d   = i2cmrt_pkg::ACT_SEND;
                tx_d    = saddr_q;
                phase_d = i2cmrt_pkg::PH_ADDR;
              end
              i2cmrt_pkg::PH_ADDR: begin
                if (is_read_q) begin
                  act_d   = i2cmrt_pkg::ACT_START;
                  phase_d = i2cmrt_pkg::PH_RESTART;
                end else if (len_q == '0) begin
                  act_d   = i2cmrt_pkg::ACT_STOP;
                  done_d  = 1'b1;
                  phase_d = i2cmrt_pkg::PH_IDLE;
                end else begin
                  act_d   = i2cmrt_pkg::ACT_SEND;
                  tx_d    = buf_rdata;
                  phase_d = i2cmrt_pkg::PH_WDATA;
                end
              end
              i2cmrt_pkg::PH_WDATA: begin
                done_cnt_d = inc1[CW-1:0];
                if (inc1 >= {1'b0, len_q}) begin
                  act_d   = i2cmrt_pkg::ACT_STOP;
                  done_d  = 1'b1;
                  phase_d = i2cmrt_pkg::PH_IDLE;
                end else begin
                  act_d = i2cmrt_pkg::ACT_SEND;
                  tx_d  = buf_rdata;
                end
              end
              i2cmrt_pkg::PH_RESTART: begin
                act_d   = i2cmrt_pkg::ACT_SEND;
                tx_d    = target_q | 8'h01;
                phase_d = i2cmrt_pkg::PH_SLAR;
              end
              i2cmrt_pkg::PH_SLAR: begin
                if (len_q <= CW'(1)) begin
                  act_d   = i2cmrt_pkg::ACT_RX_NACK;
                  phase_d = i2cmrt_pkg::PH_LAST;
                end else begin
                  act_d   = i2cmrt_pkg::ACT_RX_ACK;
                  phase_d = i2cmrt_pkg::PH_RDATA;
                end
              end
              i2cmrt_pkg::PH_RDATA: begin
                rdata_d    = rx_byte_i;
                rvalid_d   = 1'b1;
                done_cnt_d = inc1[CW-1:0];
                if (inc2 >= {1'b0, len_q}) begin
                  act_d   = i2cmrt_pkg::ACT_RX_NACK;
                  phase_d = i2cmrt_pkg::PH_LAST;
                end else begin
                  act_d = i2cmrt_pkg::ACT_RX_ACK;
                end
              end
              default: begin
                rdata_d  = rx_byte_i;
                rvalid_d = 1'b1;
                act_d    = i2cmrt_pkg::ACT_STOP;
                done_d   = 1'b1;
                phase_d  = i2cmrt_pkg::PH_IDLE;
              end
            endcase
          end
        end
      end
    endcase

    // Prefetch the byte that the next data step sends
    nxt = {1'b0, (in_acc ? done_cnt_d : done_cnt_q)} + 1'b1;
    if ((in_acc ? phase_d : phase_q) == i2cmrt_pkg::PH_ADDR) begin
      buf_raddr = '0;
    end else begin
      buf_raddr = nxt[AW-1:0];
    end
  end

  i2cmrt_ram #(
    .WIDTH (8),
    .DEPTH (MAX_BYTES)
  ) u_buf (
    .clk_i   (clk_i),
    .we_i    (in_acc & buf_we),
    .waddr_i (load_ptr_q[AW-1:0]),
    .wdata_i (write_data_i),
    .raddr_i (buf_raddr),
    .rdata_o (buf_rdata)
  );

  // Hold the target address
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= i2cmrt_pkg::TARGET_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      target_q <= cfg_wdata_i;
    end
  end

  // Advance transfer state on each accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= i2cmrt_pkg::PH_IDLE;
      is_read_q  <= 1'b0;
      saddr_q    <= 8'h00;
      len_q      <= '0;
      done_cnt_q <= '0;
      load_ptr_q <= '0;
    end else if (in_acc) begin
      phase_q    <= phase_d;
      is_read_q  <= is_read_d;
      saddr_q    <= saddr_d;
      len_q      <= len_d;
      done_cnt_q <= done_cnt_d;
      load_ptr_q <= load_ptr_d;
    end
  end

  // Output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      act_q    <= act_d;
      tx_q     <= tx_d;
      rdata_q  <= rdata_d;
      rvalid_q <= rvalid_d;
      done_q   <= done_d;
      err_q    <= err_d;
      stage_q  <= stage_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign bus_action_o  = act_q;
  assign tx_byte_o     = tx_q;
  assign read_data_o   = rdata_q;
  assign read_valid_o  = rvalid_q;
  assign done_res_o    = done_q;
  assign error_o       = err_q;
  assign error_stage_o = stage_q;

`ifndef ASSERT_OFF
  // Every accepted item leaves a result in the output register
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_valid_o)
    else $error("accepted item produced no result");

  // A begin taken while idle enters the start phase and asks for START
  a_begin_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && phase_q == i2cmrt_pkg::PH_IDLE &&
     (command_i == i2cmrt_pkg::CMD_WRITE || command_i == i2cmrt_pkg::CMD_READ))
    |=> (phase_q == i2cmrt_pkg::PH_START && bus_action_o == i2cmrt_pkg::ACT_START))
    else $error("begin did not start a transfer");

  // A finished or aborted transfer leaves the sequencer idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && done_d) |=> (phase_q == i2cmrt_pkg::PH_IDLE && done_res_o))
    else $error("transfer end did not return to idle");

  // Progress never passes the transfer length
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != i2cmrt_pkg::PH_IDLE) |-> (done_cnt_q <= len_q && len_q <= MaxLen))
    else $error("byte count beyond transfer length");
`endif

endmodule

`default_nettype wire

FILE: verif/tb_i2c_master_register_transfer.sv
module tb_i2c_master_register_transfer;

  localparam int BUF_DEPTH   = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PLAN_SIDE   = 0;  // sequencer copy that shapes the stimulus
  localparam int CHECK_SIDE  = 1;  // sequencer copy that predicts the results
  localparam int NUM_PHASES  = 6;
  localparam int PHASE_GOAL  = 150;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] reg_address;
    logic [4:0] byte_count;
    logic [7:0] write_data;
    logic [7:0] status_code;
    logic [7:0] rx_byte;
  } xfer_item_t;

  typedef struct packed {
    logic [2:0] bus_action;
    logic [7:0] tx_byte;
    logic [7:0] read_data;
    logic       read_valid;
    logic       done_res;
    logic       error;
    logic [2:0] error_stage;
  } bus_result_t;

  localparam int ITEM_W = $bits(xfer_item_t);

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       cfg_valid_i   = 1'b0;
  logic       cfg_ready_o;
  logic [7:0] cfg_wdata_i   = 8'h00;
  logic       in_valid_i    = 1'b0;
  logic       in_stall_o;
  logic [1:0] command_i     = i2cmrt_pkg::CMD_LOAD;
  logic [7:0] reg_address_i = 8'h00;
  logic [4:0] byte_count_i  = 5'd0;
  logic [7:0] write_data_i  = 8'h00;
  logic [7:0] status_code_i = 8'h00;
  logic [7:0] rx_byte_i     = 8'h00;
  logic       out_valid_o;
  logic       out_stall_i   = 1'b0;
  logic [2:0] bus_action_o;
  logic [7:0] tx_byte_o;
  logic [7:0] read_data_o;
  logic       read_valid_o;
  logic       done_res_o;
  logic       error_o;
  logic [2:0] error_stage_o;

  i2c_master_register_transfer #(.MAX_BYTES(BUF_DEPTH)) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .command_i     (command_i),
    .reg_address_i (reg_address_i),
    .byte_count_i  (byte_count_i),
    .write_data_i  (write_data_i),
    .status_code_i (status_code_i),
    .rx_byte_i     (rx_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .bus_action_o  (bus_action_o),
    .tx_byte_o     (tx_byte_o),
    .read_data_o   (read_data_o),
    .read_valid_o  (read_valid_o),
    .done_res_o    (done_res_o),
    .error_o       (error_o),
    .error_stage_o (error_stage_o)
  );

  // Sequencer state, one copy per side
  logic [3:0] seq_phase    [2];
  logic       seq_is_read  [2];
  logic [7:0] seq_reg_addr [2];
  logic [4:0] seq_length   [2];
  logic [4:0] seq_sent     [2];
  logic [4:0] seq_load_ptr [2];
  logic [7:0] seq_buffer   [2][BUF_DEPTH];
  int         seq_filled   [2];
  logic [7:0] seq_target   [2];

  xfer_item_t  pending_commands [$];
  bus_result_t expected_actions [$];

  int send_gap_pct   = 0;
  int recv_stall_pct = 0;
  int error_count    = 0;
  int cycle_count    = 0;
  int items_planned  = 0;
  int items_accepted = 0;
  int results_seen   = 0;
  int transfers_ok   = 0;
  int transfers_cut  = 0;
  int bytes_read     = 0;

  always #5 clk_i = ~clk_i;

  // Status code the engine must report in a given phase
  function automatic logic [7:0] awaited_status(input logic [3:0] ph);
    case (ph)
      i2cmrt_pkg::PH_START:   return i2cmrt_pkg::ST_START;
      i2cmrt_pkg::PH_SLAW:    return i2cmrt_pkg::ST_SLAW_ACK;
      i2cmrt_pkg::PH_ADDR,
      i2cmrt_pkg::PH_WDATA:   return i2cmrt_pkg::ST_DATA_ACK;
      i2cmrt_pkg::PH_RESTART: return i2cmrt_pkg::ST_RESTART;
      i2cmrt_pkg::PH_SLAR:    return i2cmrt_pkg::ST_SLAR_ACK;
      i2cmrt_pkg::PH_RDATA:   return i2cmrt_pkg::ST_RX_ACK;
      i2cmrt_pkg::PH_LAST:    return i2cmrt_pkg::ST_RX_NACK;
      default:                return i2cmrt_pkg::ST_BUS_ERROR;
    endcase
  endfunction

  // Advance one sequencer copy by one item and return the bus action it causes
  function automatic bus_result_t sequence_bus_step(input int u, input xfer_item_t it);
    bus_result_t r;
    logic [4:0]  cnt;
    logic [3:0]  ph;
    logic [3:0]  stage;
    r  = '0;
    ph = seq_phase[u];
    case (it.command)
      i2cmrt_pkg::CMD_LOAD: begin
        if (ph == i2cmrt_pkg::PH_IDLE && seq_load_ptr[u] < BUF_DEPTH) begin
          seq_buffer[u][seq_load_ptr[u][3:0]] = it.write_data;
          seq_load_ptr[u] = seq_load_ptr[u] + 5'd1;
          if (seq_load_ptr[u] > seq_filled[u]) seq_filled[u] = seq_load_ptr[u];
        end
      end
      i2cmrt_pkg::CMD_WRITE, i2cmrt_pkg::CMD_READ: begin
        if (ph == i2cmrt_pkg::PH_IDLE) begin
          cnt = (it.byte_count > BUF_DEPTH) ? 5'(BUF_DEPTH) : it.byte_count;
          seq_is_read[u] = (it.command == i2cmrt_pkg::CMD_READ);
          if (seq_is_read[u] && cnt == 5'd0) cnt = 5'd1;
          seq_length[u]   = cnt;
          seq_sent[u]     = 5'd0;
          seq_reg_addr[u] = it.reg_address;
          if (!seq_is_read[u]) seq_load_ptr[u] = 5'd0;
          seq_phase[u] = i2cmrt_pkg::PH_START;
          r.bus_action = i2cmrt_pkg::ACT_START;
        end
      end
      default: begin
        if (ph != i2cmrt_pkg::PH_IDLE) begin
          if (it.status_code != awaited_status(ph)) begin
            // abort: report the failing stage, recover the bus on a bus error
            stage         = ph - 4'd1;
            r.done_res    = 1'b1;
            r.error       = 1'b1;
            r.error_stage = stage[2:0];
            r.bus_action  = (it.status_code == i2cmrt_pkg::ST_BUS_ERROR) ?
                            i2cmrt_pkg::ACT_RECOVER : i2cmrt_pkg::ACT_NONE;
            seq_phase[u]  = i2cmrt_pkg::PH_IDLE;
          end else begin
            case (ph)
              i2cmrt_pkg::PH_START: begin
                r.bus_action = i2cmrt_pkg::ACT_SEND;
                r.tx_byte    = seq_target[u];
                seq_phase[u] = i2cmrt_pkg::PH_SLAW;
              end
              i2cmrt_pkg::PH_SLAW: begin
                r.bus_action = i2cmrt_pkg::ACT_SEND;
                r.tx_byte    = seq_reg_addr[u];
                seq_phase[u] = i2cmrt_pkg::PH_ADDR;
              end
              i2cmrt_pkg::PH_ADDR: begin
                if (seq_is_read[u]) begin
                  r.bus_action = i2cmrt_pkg::ACT_START;
                  seq_phase[u] = i2cmrt_pkg::PH_RESTART;
                end else if (seq_length[u] == 5'd0) begin
                  r.bus_action = i2cmrt_pkg::ACT_STOP;
                  r.done_res   = 1'b1;
                  seq_phase[u] = i2cmrt_pkg::PH_IDLE;
                end else begin
                  r.bus_action = i2cmrt_pkg::ACT_SEND;
                  r.tx_byte    = seq_buffer[u][0];
                  seq_phase[u] = i2cmrt_pkg::PH_WDATA;
                end
              end
              i2cmrt_pkg::PH_WDATA: begin
                seq_sent[u] = seq_sent[u] + 5'd1;
                if (seq_sent[u] >= seq_length[u]) begin
                  r.bus_action = i2cmrt_pkg::ACT_STOP;
                  r.done_res   = 1'b1;
                  seq_phase[u] = i2cmrt_pkg::PH_IDLE;
                end else begin
                  r.bus_action = i2cmrt_pkg::ACT_SEND;
                  r.tx_byte    = seq_buffer[u][seq_sent[u][3:0]];
                end
              end
              i2cmrt_pkg::PH_RESTART: begin
                r.bus_action = i2cmrt_pkg::ACT_SEND;
                r.tx_byte    = seq_target[u] | 8'h01;
                seq_phase[u] = i2cmrt_pkg::PH_SLAR;
              end
              i2cmrt_pkg::PH_SLAR: begin
                if (seq_length[u] <= 5'd1) begin
                  r.bus_action = i2cmrt_pkg::ACT_RX_NACK;
                  seq_phase[u] = i2cmrt_pkg::PH_LAST;
                end else begin
                  r.bus_action = i2cmrt_pkg::ACT_RX_ACK;
                  seq_phase[u] = i2cmrt_pkg::PH_RDATA;
                end
              end
              i2cmrt_pkg::PH_RDATA: begin
                r.read_data  = it.rx_byte;
                r.read_valid = 1'b1;
                seq_sent[u]  = seq_sent[u] + 5'd1;
                if (seq_sent[u] + 5'd1 >= seq_length[u]) begin
                  r.bus_action = i2cmrt_pkg::ACT_RX_NACK;
                  seq_phase[u] = i2cmrt_pkg::PH_LAST;
                end else begin
                  r.bus_action = i2cmrt_pkg::ACT_RX_ACK;
                end
              end
              default: begin
                r.read_data  = it.rx_byte;
                r.read_valid = 1'b1;
                r.bus_action = i2cmrt_pkg::ACT_STOP;
                r.done_res   = 1'b1;
                seq_phase[u] = i2cmrt_pkg::PH_IDLE;
              end
            endcase
          end
        end
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got_v, input int want_v);
    error_count++;
    if (error_count <= 40)
      $display("MISMATCH result %0d %s: got %0h expected %0h",
               results_seen, what, got_v, want_v);
  endtask

  function automatic xfer_item_t make_item(input logic [1:0] cmd, input logic [7:0] addr,
                                           input logic [4:0] cnt, input logic [7:0] data,
                                           input logic [7:0] st, input logic [7:0] rx);
    return {cmd, addr, cnt, data, st, rx};
  endfunction

  // Status event with the other fields at zero
  function automatic xfer_item_t status_item(input logic [7:0] st, input logic [7:0] rx);
    return make_item(i2cmrt_pkg::CMD_STATUS, 8'h00, 5'd0, 8'h00, st, rx);
  endfunction

  // All fields random, command fixed
  function automatic xfer_item_t scrambled_item(input logic [1:0] cmd);
    xfer_item_t it;
    it         = ITEM_W'({$urandom, $urandom});
    it.command = cmd;
    return it;
  endfunction

  // Queue an item and track what it does to the planning copy
  task automatic queue_item(input xfer_item_t it);
    bus_result_t effect;
    logic [4:0]  ptr_was;
    ptr_was = seq_load_ptr[PLAN_SIDE];
    effect  = sequence_bus_step(PLAN_SIDE, it);
    if (effect != '0 || seq_load_ptr[PLAN_SIDE] != ptr_was) items_planned++;
    pending_commands.push_back(it);
  endtask

  // One write or read with random content, noise and the odd bad status
  task automatic run_transfer();
    xfer_item_t it;
    int         loads;
    int         roll;
    if ($urandom_range(0, 1) == 1) begin
      loads = ($urandom_range(0, 9) == 0) ? 20 : $urandom_range(0, 6);
      repeat (loads) queue_item(scrambled_item(i2cmrt_pkg::CMD_LOAD));
      it = scrambled_item(i2cmrt_pkg::CMD_WRITE);
      // never send a buffer entry that was not loaded
      if (seq_filled[PLAN_SIDE] < BUF_DEPTH)
        it.byte_count = 5'($urandom_range(0, seq_filled[PLAN_SIDE]));
      else if ($urandom_range(0, 3) != 0)
        it.byte_count = 5'($urandom_range(0, 5));
    end else begin
      it = scrambled_item(i2cmrt_pkg::CMD_READ);
      if ($urandom_range(0, 3) != 0) it.byte_count = 5'($urandom_range(0, 5));
    end
    queue_item(it);
    while (seq_phase[PLAN_SIDE] != i2cmrt_pkg::PH_IDLE) begin
      roll = $urandom_range(0, 99);
      if (roll < 2) begin
        queue_item(scrambled_item(2'($urandom_range(1, 2))));
      end else if (roll < 4) begin
        queue_item(scrambled_item(i2cmrt_pkg::CMD_LOAD));
      end else begin
        it = scrambled_item(i2cmrt_pkg::CMD_STATUS);
        if (roll >= 7)
          it.status_code = awaited_status(seq_phase[PLAN_SIDE]);
        else if ($urandom_range(0, 2) == 0)
          it.status_code = i2cmrt_pkg::ST_BUS_ERROR;
        queue_item(it);
      end
    end
  endtask

  // Cycle watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TIMEOUT after %0d cycles", cycle_count);
      $display("tb_i2c_master_register_transfer: errors");
      $finish;
    end
  end

  // Drive items: predict on acceptance, present the next one when free
  always @(posedge clk_i) begin : drive_items
    xfer_item_t  shown;
    bus_result_t predicted;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        shown     = {command_i, reg_address_i, byte_count_i, write_data_i,
                     status_code_i, rx_byte_i};
        predicted = sequence_bus_step(CHECK_SIDE, shown);
        expected_actions.push_back(predicted);
        items_accepted++;
        if (predicted.done_res && !predicted.error) transfers_ok++;
        if (predicted.error) transfers_cut++;
        if (predicted.read_valid) bytes_read++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_commands.size() > 0 && $urandom_range(0, 99) >= send_gap_pct) begin
          shown         = pending_commands.pop_front();
          command_i     <= shown.command;
          reg_address_i <= shown.reg_address;
          byte_count_i  <= shown.byte_count;
          write_data_i  <= shown.write_data;
          status_code_i <= shown.status_code;
          rx_byte_i     <= shown.rx_byte;
          in_valid_i    <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Check results in order and drive the result stall
  always @(posedge clk_i) begin : check_results
    bus_result_t got;
    bus_result_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        got = {bus_action_o, tx_byte_o, read_data_o, read_valid_o, done_res_o,
               error_o, error_stage_o};
        if (expected_actions.size() == 0) begin
          report_mismatch("unexpected result", got, 0);
        end else begin
          want = expected_actions.pop_front();
          if (got.bus_action !== want.bus_action)
            report_mismatch("bus_action", got.bus_action, want.bus_action);
          if (got.tx_byte !== want.tx_byte)
            report_mismatch("tx_byte", got.tx_byte, want.tx_byte);
          if (got.read_data !== want.read_data)
            report_mismatch("read_data", got.read_data, want.read_data);
          if (got.read_valid !== want.read_valid)
            report_mismatch("read_valid", got.read_valid, want.read_valid);
          if (got.done_res !== want.done_res)
            report_mismatch("done_res", got.done_res, want.done_res);
          if (got.error !== want.error)
            report_mismatch("error", got.error, want.error);
          if (got.error_stage !== want.error_stage)
            report_mismatch("error_stage", got.error_stage, want.error_stage);
        end
      end
      out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Reset, then phases of stimulus, each with a target address setting and idling levels
  initial begin : run_phases
    int         phase_i;
    logic [7:0] cfg_value;
    for (int u = 0; u < 2; u++) begin
      seq_phase[u]    = i2cmrt_pkg::PH_IDLE;
      seq_is_read[u]  = 1'b0;
      seq_reg_addr[u] = 8'h00;
      seq_length[u]   = 5'd0;
      seq_sent[u]     = 5'd0;
      seq_load_ptr[u] = 5'd0;
      seq_filled[u]   = 0;
      seq_target[u]   = i2cmrt_pkg::TARGET_RESET;
      for (int i = 0; i < BUF_DEPTH; i++) seq_buffer[u][i] = 8'h00;
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (phase_i = 0; phase_i < NUM_PHASES; phase_i++) begin
      // write the target address while nothing is in flight
      if (phase_i > 0) begin
        case (phase_i)
          1:       cfg_value = 8'h00;
          2:       cfg_value = 8'hFE;
          5:       cfg_value = i2cmrt_pkg::TARGET_RESET;
          default: cfg_value = 8'($urandom_range(0, 254));
        endcase
        @(posedge clk_i);
        cfg_valid_i <= 1'b1;
        cfg_wdata_i <= cfg_value;
        @(posedge clk_i);
        while (!cfg_ready_o) @(posedge clk_i);
        cfg_valid_i <= 1'b0;
        seq_target[CHECK_SIDE] = cfg_value;
      end

      @(negedge clk_i);
      if (phase_i < 2) begin
        send_gap_pct   = 27;
        recv_stall_pct = 74;
      end else if (phase_i < 4) begin
        send_gap_pct   = 74;
        recv_stall_pct = 27;
      end else begin
        send_gap_pct   = 0;
        recv_stall_pct = 0;
      end

      if (phase_i == 0) begin
        // status while idle
        queue_item(status_item(i2cmrt_pkg::ST_START, 8'h00));
        // read of zero bytes runs as a one-byte read
        queue_item(make_item(i2cmrt_pkg::CMD_READ, 8'hFF, 5'd0, 8'hFF, 8'hFF, 8'hFF));
        queue_item(status_item(i2cmrt_pkg::ST_START, 8'h00));
        queue_item(status_item(i2cmrt_pkg::ST_SLAW_ACK, 8'h00));
        queue_item(status_item(i2cmrt_pkg::ST_DATA_ACK, 8'h00));
        queue_item(status_item(i2cmrt_pkg::ST_RESTART, 8'h00));
        queue_item(status_item(i2cmrt_pkg::ST_SLAR_ACK, 8'h00));
        queue_item(status_item(i2cmrt_pkg::ST_RX_NACK, 8'hFF));
        // two-byte write with extreme data
        queue_item(make_item(i2cmrt_pkg::CMD_LOAD, 8'hFF, 5'd31, 8'h00, 8'hFF, 8'h00));
        queue_item(make_item(i2cmrt_pkg::CMD_LOAD, 8'h00, 5'd0, 8'hFF, 8'h00, 8'hFF));
        queue_item(make_item(i2cmrt_pkg::CMD_WRITE, 8'h00, 5'd2, 8'h00, 8'h00, 8'h00));
        queue_item(status_item(i2cmrt_pkg::ST_START, 8'h00));
        queue_item(status_item(i2cmrt_pkg::ST_SLAW_ACK, 8'h00));
        queue_item(status_item(i2cmrt_pkg::ST_DATA_ACK, 8'h00));
        queue_item(status_item(i2cmrt_pkg::ST_DATA_ACK, 8'h00));
        queue_item(status_item(i2cmrt_pkg::ST_DATA_ACK, 8'h00));
        // zero-byte write stops right after the address
        queue_item(make_item(i2cmrt_pkg::CMD_WRITE, 8'h5A, 5'd0, 8'h00, 8'h00, 8'h00));
        queue_item(status_item(i2cmrt_pkg::ST_START, 8'h00));
        queue_item(status_item(i2cmrt_pkg::ST_SLAW_ACK, 8'h00));
        queue_item(status_item(i2cmrt_pkg::ST_DATA_ACK, 8'h00));
        // begin and load while busy are dropped, then a bus error recovers
        queue_item(make_item(i2cmrt_pkg::CMD_WRITE, 8'hA5, 5'd1, 8'h00, 8'h00, 8'h00));
        queue_item(status_item(i2cmrt_pkg::ST_START, 8'h00));
        queue_item(make_item(i2cmrt_pkg::CMD_READ, 8'h33, 5'd4, 8'h00, 8'h00, 8'h00));
        queue_item(make_item(i2cmrt_pkg::CMD_LOAD, 8'h00, 5'd0, 8'h77, 8'h00, 8'h00));
        queue_item(status_item(i2cmrt_pkg::ST_BUS_ERROR, 8'h00));
      end else begin
        items_planned = 0;
        while (items_planned < PHASE_GOAL) begin
          if ($urandom_range(0, 99) < 8)
            queue_item(scrambled_item(i2cmrt_pkg::CMD_STATUS));
          else
            run_transfer();
        end
      end

      // hold until every item is taken and every result is back
      @(negedge clk_i);
      while (pending_commands.size() != 0 || in_valid_i || expected_actions.size() != 0)
        @(negedge clk_i);
    end

    repeat (8) @(posedge clk_i);
    if (expected_actions.size() != 0)
      report_mismatch("results never delivered", expected_actions.size(), 0);
    $display("Ran %0d items over %0d target address settings, %0d results checked",
             items_accepted, NUM_PHASES, results_seen);
    $display("Transfers completed %0d, aborted %0d, bytes read back %0d",
             transfers_ok, transfers_cut, bytes_read);
    if (error_count == 0) begin
      $display("tb_i2c_master_register_transfer: clean");
    end else begin
      $display("tb_i2c_master_register_transfer: errors");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/i2cmrt_pkg.sv
hdl/i2cmrt_ram.sv
hdl/i2c_master_register_transfer.sv
verif/tb_i2c_master_register_transfer.sv
